/* hw/rtl/kett_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kett_pkg
// Types, constants and helpers shared by the key event tracker files.
// ---------------------------------------------------------------------------
package kett_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int KEY_COUNT   = 256;
    localparam int QAW         = $clog2(QUEUE_DEPTH);
    localparam int KAW         = $clog2(KEY_COUNT);

    // Request codes.
    localparam logic [2:0] REQ_SAMPLE  = 3'd0;
    localparam logic [2:0] REQ_POP     = 3'd1;
    localparam logic [2:0] REQ_PEEK    = 3'd2;
    localparam logic [2:0] REQ_DTIME   = 3'd3;
    localparam logic [2:0] REQ_DCOUNT  = 3'd4;
    localparam logic [2:0] REQ_UCOUNT  = 3'd5;
    localparam logic [2:0] REQ_SHIFT   = 3'd6;
    localparam logic [2:0] REQ_FLUSH   = 3'd7;

    // Configuration register indexes.
    localparam logic CFG_THRESHOLD = 1'b0;
    localparam logic CFG_DEBUG_EN  = 1'b1;

    // Scancodes with special handling.
    localparam logic [7:0] SC_ESC     = 8'h01;
    localparam logic [7:0] SC_ENTER   = 8'h1C;
    localparam logic [7:0] SC_BACKSP  = 8'h0E;
    localparam int         MOD_KEYS   = 7;
    localparam logic [7:0] MOD_CODE [MOD_KEYS] = '{8'h2A, 8'h36, 8'h38, 8'hB8,
                                                    8'h1D, 8'h9D, 8'hD3};

    localparam logic [7:0] THRESHOLD_RESET = 8'd30;

    // One key's tracking record.
    typedef struct packed {
        logic        pressed;
        logic        down_flag;
        logic        prev_level;
        logic [7:0]  hold;
        logic [31:0] went_down;
        logic [31:0] held_sum;
        logic [7:0]  press_cnt;
        logic [7:0]  rel_cnt;
    } t_key_entry;

    localparam int KEY_W = $bits(t_key_entry);

    // One queued key event.
    typedef struct packed {
        logic [11:0] word;
        logic [31:0] stamp;
    } t_queue_entry;

    localparam int QUEUE_W = $bits(t_queue_entry);

    // Record written by reset and flush.
    function automatic t_key_entry key_reset_entry(input logic [31:0] now);
        t_key_entry e;
        e           = '0;
        e.down_flag = 1'b1;
        e.went_down = now;
        return e;
    endfunction

endpackage

/* hw/rtl/kett_ram.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kett_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ---------------------------------------------------------------------------
module kett_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

/* hw/rtl/key_event_tracker_fifo.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// key_event_tracker_fifo
// Per-key press, release and hold tracking with a ring of key events.
// ---------------------------------------------------------------------------
// The block handles one request at a time. Key samples, reads and pops pass
// from the accepted beat to the result beat through the accept cycle, the
// modify step and S_OUT: the accept cycle issues the read of the key record
// or queue slot, the next cycle modifies and writes back, and S_OUT then
// loads the output register when the output is not stalled. A flush walks
// the key memory one record per cycle. After reset the same clearing pass
// runs before the first beat is taken; configuration writes are taken at any time.
module key_event_tracker_fifo (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_req_type,
    input  logic [7:0]  i_key_code,
    input  logic        i_key_level,
    input  logic [31:0] i_now_time,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [11:0] o_key_word,
    output logic [31:0] o_key_stamp,
    output logic [7:0]  o_count_value,
    output logic [31:0] o_time_value,
    output logic        o_queue_nonempty,
    output logic [3:0]  o_modifier_flags,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    import kett_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_MOD   = 4'b0010,
        S_CLEAR = 4'b0100,
        S_OUT   = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [7:0]          r_thr;
    logic                r_dbg_en;
    logic [2:0]          r_req;
    logic [7:0]          r_key;
    logic                r_level;
    logic [31:0]         r_now;
    logic [QAW-1:0]      r_head, n_head, r_tail, n_tail;
    logic [MOD_KEYS-1:0] r_mod_down, n_mod_down;
    logic [KAW-1:0]      r_clr_addr;
    logic [31:0]         r_flush_time;
    logic                r_clr_reply;
    logic [11:0]         r_res_word, n_res_word;
    logic [31:0]         r_res_stamp, n_res_stamp;
    logic [7:0]          r_res_count, n_res_count;
    logic [31:0]         r_res_tval, n_res_tval;
    logic                r_out_valid;
    logic [11:0]         r_out_word;
    logic [31:0]         r_out_stamp;
    logic [7:0]          r_out_count;
    logic [31:0]         r_out_tval;
    logic                r_out_ne;
    logic [3:0]          r_out_flags;

    logic                in_accept;
    logic                out_load;
    logic                key_valid;
    logic                key_we;
    logic [KAW-1:0]      key_waddr;
    t_key_entry          key_q, key_d;
    logic                q_we;
    t_queue_entry        q_q, q_d;
    logic [QAW-1:0]      tail_next, head_next;
    logic [3:0]          n_flags;
    logic [3:0]          cur_flags;
    logic                queue_it;
    logic [7:0]          hold_new;

    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign key_valid   = ({1'b0, r_key} < 9'(KEY_COUNT));

    // Next ring positions.
    assign tail_next = (r_tail == QAW'(QUEUE_DEPTH - 1)) ? '0 : r_tail + 1'b1;
    assign head_next = (r_head == QAW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;

    // Modifier flags from a set of modifier key levels.
    function automatic logic [3:0] mod_flags(input logic [MOD_KEYS-1:0] m,
                                             input logic dbg);
        return {dbg & m[6], m[4] | m[5], m[2] | m[3], m[0] | m[1]};
    endfunction

    // Hold counter increment that toggles between thr+1 and thr+2 past the threshold, or saturates at 255.
    function automatic logic [7:0] bump(input logic [7:0] c, input logic [7:0] thr);
        logic [8:0] top;
        logic [8:0] nc;
        top = {1'b0, thr} + 9'd2;
        nc  = {1'b0, c} + 9'd1;
        if (top > 9'd255) begin
            return (nc > 9'd255) ? 8'hFF : nc[7:0];
        end else if (nc > top) begin
            return thr + 8'd1;
        end
        return nc[7:0];
    endfunction

    assign cur_flags = mod_flags(r_mod_down, r_dbg_en);

    // Key record and event queue memories.
    kett_ram #(.WIDTH(KEY_W), .DEPTH(KEY_COUNT)) u_key_ram (
        .i_clk     (i_clk),
        .i_wr_en   (key_we),
        .i_wr_addr (key_waddr),
        .i_wr_data (key_d),
        .i_rd_en   (in_accept),
        .i_rd_addr (i_key_code[KAW-1:0]),
        .o_rd_data (key_q)
    );

    kett_ram #(.WIDTH(QUEUE_W), .DEPTH(QUEUE_DEPTH)) u_queue_ram (
        .i_clk     (i_clk),
        .i_wr_en   (q_we),
        .i_wr_addr (r_tail),
        .i_wr_data (q_d),
        .i_rd_en   (in_accept),
        .i_rd_addr (r_head),
        .o_rd_data (q_q)
    );

    // Read-modify-write of the key record and the queue.
    always_comb begin
        key_d       = key_q;
        key_we      = 1'b0;
        key_waddr   = r_key[KAW-1:0];
        q_we        = 1'b0;
        q_d         = '0;
        queue_it    = 1'b0;
        hold_new    = bump(key_q.hold, r_thr);
        n_mod_down  = r_mod_down;
        n_head      = r_head;
        n_tail      = r_tail;
        n_res_word  = r_res_word;
        n_res_stamp = r_res_stamp;
        n_res_count = r_res_count;
        n_res_tval  = r_res_tval;
        n_flags     = cur_flags;
        n_state     = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_res_word  = '0;
                    n_res_stamp = '0;
                    n_res_count = '0;
                    n_res_tval  = '0;
                    if (i_req_type == REQ_FLUSH) begin
                        n_head     = '0;
                        n_tail     = '0;
                        n_mod_down = '0;
                        n_state    = S_CLEAR;
                    end else begin
                        n_state = S_MOD;
                    end
                end
            end
            S_MOD: begin
                n_state = S_OUT;
                case (r_req)
                    REQ_SAMPLE: begin
                        if (key_valid) begin
                            key_we = 1'b1;
                            if (key_q.prev_level == r_level) begin
                                if (r_level) begin
                                    key_d.hold = hold_new;
                                    queue_it   = (hold_new > r_thr) && hold_new[0];
                                end
                            end else if (r_level) begin
                                key_d.pressed   = 1'b1;
                                key_d.press_cnt = key_q.press_cnt + 8'd1;
                                key_d.down_flag = 1'b1;
                                key_d.went_down = r_now;
                                key_d.hold      = hold_new;
                                queue_it        = 1'b1;
                            end else begin
                                key_d.pressed   = 1'b0;
                                key_d.rel_cnt   = key_q.rel_cnt + {7'd0, key_q.down_flag};
                                key_d.down_flag = 1'b0;
                                key_d.hold      = '0;
                                key_d.held_sum  = key_q.held_sum + (r_now - key_q.went_down);
                            end
                            key_d.prev_level = r_level;
                            for (int j = 0; j < MOD_KEYS; j++) begin
                                if (r_key == MOD_CODE[j]) begin
                                    n_mod_down[j] = key_d.pressed;
                                end
                            end
                            n_flags = mod_flags(n_mod_down, r_dbg_en);
                            // Queue the event, if the sample calls for one, unless the ring is full.
                            q_d.word[7:0] = r_key;
                            q_d.word[11]  = n_flags[3];
                            if (r_key != SC_ESC && r_key != SC_ENTER && r_key != SC_BACKSP) begin
                                q_d.word[10:8] = n_flags[2:0];
                            end
                            q_d.stamp = r_now;
                            if (queue_it && (tail_next != r_head)) begin
                                q_we   = 1'b1;
                                n_tail = tail_next;
                            end
                        end
                    end
                    REQ_POP, REQ_PEEK: begin
                        if (r_head != r_tail) begin
                            n_res_word  = q_q.word;
                            n_res_stamp = q_q.stamp;
                            if (r_req == REQ_POP) begin
                                n_head = head_next;
                            end
                        end
                    end
                    REQ_DTIME: begin
                        if (key_valid) begin
                            key_we = 1'b1;
                            if (!key_q.pressed) begin
                                n_res_tval     = key_q.held_sum;
                                key_d.held_sum = '0;
                            end else begin
                                n_res_tval      = r_now - key_q.went_down;
                                key_d.went_down = r_now;
                            end
                        end
                    end
                    REQ_DCOUNT: begin
                        if (key_valid) begin
                            key_we          = 1'b1;
                            n_res_count     = key_q.press_cnt;
                            key_d.press_cnt = '0;
                        end
                    end
                    REQ_UCOUNT: begin
                        if (key_valid) begin
                            key_we        = 1'b1;
                            n_res_count   = key_q.rel_cnt;
                            key_d.rel_cnt = '0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_CLEAR: begin
                key_we    = 1'b1;
                key_waddr = r_clr_addr;
                key_d     = key_reset_entry(r_flush_time);
                if (r_clr_addr == KAW'(KEY_COUNT - 1)) begin
                    n_state = r_clr_reply ? S_OUT : S_IDLE;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign out_load = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);

    // Control state, configuration and request registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_thr        <= THRESHOLD_RESET;
            r_dbg_en     <= 1'b1;
            r_head       <= '0;
            r_tail       <= '0;
            r_mod_down   <= '0;
            r_clr_addr   <= '0;
            r_flush_time <= '0;
            r_clr_reply  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_mod_down <= n_mod_down;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_THRESHOLD: r_thr    <= i_cfg_data;
                    CFG_DEBUG_EN:  r_dbg_en <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (in_accept && i_req_type == REQ_FLUSH) begin
                r_flush_time <= i_now_time;
                r_clr_reply  <= 1'b1;
                r_clr_addr   <= '0;
            end else if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_req   <= i_req_type;
            r_key   <= i_key_code;
            r_level <= i_key_level;
            r_now   <= i_now_time;
        end
        r_res_word  <= n_res_word;
        r_res_stamp <= n_res_stamp;
        r_res_count <= n_res_count;
        r_res_tval  <= n_res_tval;
        if (out_load) begin
            r_out_word  <= r_res_word;
            r_out_stamp <= r_res_stamp;
            r_out_count <= r_res_count;
            r_out_tval  <= r_res_tval;
            r_out_ne    <= (r_head != r_tail);
            r_out_flags <= cur_flags;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_key_word       = r_out_word;
    assign o_key_stamp      = r_out_stamp;
    assign o_count_value    = r_out_count;
    assign o_time_value     = r_out_tval;
    assign o_queue_nonempty = r_out_ne;
    assign o_modifier_flags = r_out_flags;

    // Every accepted beat goes straight to the modify step or the clearing pass.
    a_accept_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == S_MOD || r_state == S_CLEAR))
        else $error("accepted beat not followed by modify or clear");

    // The key memory is written only by the modify step or the clearing pass.
    a_key_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        key_we |-> (r_state == S_MOD || r_state == S_CLEAR))
        else $error("key record written outside modify or clear");

    // A push never makes the ring look empty.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_we |=> (r_tail != r_head))
        else $error("queue push overran the head");

endmodule

/* test/tb_key_event_tracker_fifo.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_key_event_tracker_fifo
// Self-checking bench for the key event tracker with its event ring.
// ---------------------------------------------------------------------------
// Requests are queued by the stimulus process and sent by a clocked driver.
// A behavioural model of the key records and the ring predicts each result
// beat at the moment its request beat is accepted. A clocked monitor compares
// every result beat field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module tb_key_event_tracker_fifo;
    import kett_pkg::*;

    typedef struct packed {
        logic [2:0]  req;
        logic [7:0]  code;
        logic        level;
        logic [31:0] now;
    } t_req;

    typedef struct packed {
        logic [11:0] word;
        logic [31:0] stamp;
        logic [7:0]  count;
        logic [31:0] tval;
        logic        nonempty;
        logic [3:0]  mods;
    } t_result;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  req_type = '0;
    logic [7:0]  key_code = '0;
    logic        key_level = 1'b0;
    logic [31:0] now_time = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [11:0] key_word;
    logic [31:0] key_stamp;
    logic [7:0]  count_value;
    logic [31:0] time_value;
    logic        queue_nonempty;
    logic [3:0]  modifier_flags;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [7:0]  cfg_data = '0;

    key_event_tracker_fifo dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_req_type(req_type), .i_key_code(key_code),
        .i_key_level(key_level), .i_now_time(now_time),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_key_word(key_word), .o_key_stamp(key_stamp),
        .o_count_value(count_value), .o_time_value(time_value),
        .o_queue_nonempty(queue_nonempty), .o_modifier_flags(modifier_flags),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    // Model state of the tracker.
    logic [7:0]  m_thresh;
    logic        m_dbg_en;
    logic        m_pressed [KEY_COUNT];
    logic        m_down    [KEY_COUNT];
    logic        m_prev    [KEY_COUNT];
    logic [7:0]  m_hold    [KEY_COUNT];
    logic [31:0] m_went    [KEY_COUNT];
    logic [31:0] m_held    [KEY_COUNT];
    logic [7:0]  m_presses [KEY_COUNT];
    logic [7:0]  m_releases[KEY_COUNT];
    logic [11:0] m_ring_word [QUEUE_DEPTH];
    logic [31:0] m_ring_stamp[QUEUE_DEPTH];
    int          m_head, m_tail;
    logic [31:0] m_last_press;

    t_req    pending_reqs[$];
    t_result awaited_results[$];
    int      errors = 0;
    int      results_seen = 0;
    int      in_idle_pct = 0;
    int      out_stall_pct = 0;
    bit      hold_off = 1'b0;

    // Clock.
    initial begin
        forever #10 clk = ~clk;
    end

    function automatic logic [3:0] model_mods();
        logic [3:0] m;
        m = '0;
        if (m_pressed[8'h2A] || m_pressed[8'h36]) m[0] = 1'b1;
        if (m_pressed[8'h38] || m_pressed[8'hB8]) m[1] = 1'b1;
        if (m_pressed[8'h1D] || m_pressed[8'h9D]) m[2] = 1'b1;
        if (m_dbg_en && m_pressed[8'hD3]) m[3] = 1'b1;
        return m;
    endfunction

    function automatic void bump_hold(int k);
        int top;
        int c;
        top = int'(m_thresh) + 2;
        c = int'(m_hold[k]) + 1;
        if (top > 255) begin
            if (c > 255) c = 255;
        end else if (c > top) begin
            c = int'(m_thresh) + 1;
        end
        m_hold[k] = c[7:0];
    endfunction

    function automatic void clear_keys(logic [31:0] now);
        m_head = 0;
        m_tail = 0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            m_ring_word[i] = '0;
            m_ring_stamp[i] = '0;
        end
        for (int i = 0; i < KEY_COUNT; i++) begin
            m_pressed[i] = 1'b0;
            m_down[i] = 1'b1;
            m_prev[i] = 1'b0;
            m_hold[i] = '0;
            m_went[i] = now;
            m_held[i] = '0;
            m_presses[i] = '0;
            m_releases[i] = '0;
        end
    endfunction

    function automatic void track_sample(int k, logic level, logic [31:0] now);
        logic       enqueue;
        logic [11:0] w;
        logic [3:0] m;
        int         nt;
        enqueue = 1'b0;
        if (m_prev[k] == level) begin
            if (level) begin
                bump_hold(k);
                m_last_press = now;
                if (m_hold[k] > m_thresh && m_hold[k][0]) enqueue = 1'b1;
            end
        end else if (level) begin
            m_pressed[k] = 1'b1;
            m_presses[k] = m_presses[k] + 8'd1;
            m_down[k] = 1'b1;
            m_went[k] = now;
            m_last_press = now;
            bump_hold(k);
            enqueue = 1'b1;
        end else begin
            m_pressed[k] = 1'b0;
            m_releases[k] = m_releases[k] + {7'd0, m_down[k]};
            m_down[k] = 1'b0;
            m_hold[k] = '0;
            m_held[k] = m_held[k] + (now - m_went[k]);
        end
        if (enqueue) begin
            w = {4'd0, k[7:0]};
            m = model_mods();
            if (k[7:0] != SC_ESC && k[7:0] != SC_ENTER && k[7:0] != SC_BACKSP)
                w[10:8] = m[2:0];
            w[11] = m[3];
            nt = (m_tail + 1) % QUEUE_DEPTH;
            if (nt != m_head) begin
                m_ring_word[m_tail] = w;
                m_ring_stamp[m_tail] = m_last_press;
                m_tail = nt;
            end
        end
        m_prev[k] = level;
    endfunction

    // Applies one request to the model and returns the result it causes.
    function automatic t_result track_request(t_req r);
        t_result o;
        int k;
        o = '0;
        k = r.code;
        case (r.req)
            REQ_SAMPLE: track_sample(k, r.level, r.now);
            REQ_POP, REQ_PEEK: begin
                if (m_head != m_tail) begin
                    o.word = m_ring_word[m_head];
                    o.stamp = m_ring_stamp[m_head];
                    if (r.req == REQ_POP) m_head = (m_head + 1) % QUEUE_DEPTH;
                end
            end
            REQ_DTIME: begin
                if (!m_pressed[k]) begin
                    o.tval = m_held[k];
                    m_held[k] = '0;
                end else begin
                    o.tval = r.now - m_went[k];
                    m_went[k] = r.now;
                end
            end
            REQ_DCOUNT: begin
                o.count = m_presses[k];
                m_presses[k] = '0;
            end
            REQ_UCOUNT: begin
                o.count = m_releases[k];
                m_releases[k] = '0;
            end
            REQ_SHIFT: ;
            default: clear_keys(r.now);
        endcase
        o.nonempty = (m_head != m_tail);
        o.mods = model_mods();
        return o;
    endfunction

    // Driver: presents queued requests and predicts each accepted beat.
    always @(posedge clk) begin
        if (in_valid && !in_stall) begin
            awaited_results.push_back(track_request(
                {req_type, key_code, key_level, now_time}));
        end
        if (!in_valid || !in_stall) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= in_idle_pct) begin
                t_req r;
                r = pending_reqs.pop_front();
                in_valid <= 1'b1;
                req_type <= r.req;
                key_code <= r.code;
                key_level <= r.level;
                now_time <= r.now;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall pattern.
    always @(posedge clk) begin
        out_stall <= hold_off || ($urandom_range(99) < out_stall_pct);
    end

    // Monitor: compares result beats with the oldest prediction.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            t_result got;
            t_result exp;
            got = {key_word, key_stamp, count_value, time_value,
                   queue_nonempty, modifier_flags};
            results_seen++;
            if (awaited_results.size() == 0) begin
                $display("%0t: result beat with nothing expected, got %h", $time, got);
                errors++;
            end else begin
                exp = awaited_results.pop_front();
                if (got.word != exp.word) begin
                    $display("%0t: key_word exp %h got %h", $time, exp.word, got.word);
                    errors++;
                end
                if (got.stamp != exp.stamp) begin
                    $display("%0t: key_stamp exp %h got %h", $time, exp.stamp, got.stamp);
                    errors++;
                end
                if (got.count != exp.count) begin
                    $display("%0t: count_value exp %h got %h", $time, exp.count, got.count);
                    errors++;
                end
                if (got.tval != exp.tval) begin
                    $display("%0t: time_value exp %h got %h", $time, exp.tval, got.tval);
                    errors++;
                end
                if (got.nonempty != exp.nonempty) begin
                    $display("%0t: queue_nonempty exp %b got %b", $time,
                             exp.nonempty, got.nonempty);
                    errors++;
                end
                if (got.mods != exp.mods) begin
                    $display("%0t: modifier_flags exp %h got %h", $time, exp.mods, got.mods);
                    errors++;
                end
            end
        end
    end

    function automatic void add_req(logic [2:0] q, logic [7:0] c, logic l, logic [31:0] t);
        t_req r;
        r.req = q;
        r.code = c;
        r.level = l;
        r.now = t;
        pending_reqs.push_back(r);
    endfunction

    task automatic drain();
        while (pending_reqs.size() > 0 || in_valid || awaited_results.size() > 0)
            @(negedge clk);
        repeat (KEY_COUNT + 10) @(posedge clk);
    endtask

    task automatic write_cfg(logic idx, logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        if (idx == CFG_THRESHOLD) m_thresh = val;
        else m_dbg_en = val[0];
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Random content biased towards a few keys so holds and repeats build up.
    function automatic void add_random(int n);
        logic [7:0] hot [12] = '{8'h2A, 8'h36, 8'h38, 8'hB8, 8'h1D, 8'h9D, 8'hD3,
                                 SC_ESC, SC_ENTER, SC_BACKSP, 8'h10, 8'hFF};
        logic [7:0] c;
        int         p;
        for (int i = 0; i < n; i++) begin
            c = ($urandom_range(3) == 0) ? 8'($urandom) : hot[$urandom_range(11)];
            p = $urandom_range(99);
            if (p < 60)
                add_req(REQ_SAMPLE, c, $urandom_range(3) != 0, $urandom);
            else if (p < 99)
                add_req(3'($urandom_range(1, 6)), c, 1'($urandom_range(1)), $urandom);
            else
                add_req(REQ_FLUSH, c, 1'($urandom_range(1)), $urandom);
        end
    endfunction

    // Stimulus.
    initial begin
        int waited;
        m_thresh = THRESHOLD_RESET;
        m_dbg_en = 1'b1;
        m_last_press = '0;
        clear_keys('0);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: modifiers, special keys, repeats, reads and extremes.
        write_cfg(CFG_THRESHOLD, 8'd0);
        add_req(REQ_SAMPLE, 8'h2A, 1'b1, 32'h8000_0000);
        add_req(REQ_SAMPLE, 8'h38, 1'b1, 32'h0001_0000);
        add_req(REQ_SAMPLE, 8'h1D, 1'b1, 32'h0002_0000);
        add_req(REQ_SAMPLE, 8'hD3, 1'b1, 32'h0003_0000);
        add_req(REQ_SAMPLE, SC_ESC, 1'b1, 32'h7FFF_FFFF);
        add_req(REQ_SAMPLE, SC_ENTER, 1'b1, 32'hFFFF_FFFF);
        add_req(REQ_SAMPLE, SC_BACKSP, 1'b1, 32'h0000_0001);
        add_req(REQ_SAMPLE, 8'hFF, 1'b1, 32'h1234_5678);
        for (int i = 0; i < 4; i++) add_req(REQ_SAMPLE, 8'hFF, 1'b1, 32'h100 * i);
        add_req(REQ_PEEK, 8'h00, 1'b0, '0);
        add_req(REQ_POP, 8'h00, 1'b0, '0);
        add_req(REQ_DTIME, 8'hFF, 1'b0, 32'h2000_0000);
        add_req(REQ_SAMPLE, 8'hFF, 1'b0, 32'h3000_0000);
        add_req(REQ_DTIME, 8'hFF, 1'b0, '0);
        add_req(REQ_DCOUNT, 8'hFF, 1'b0, '0);
        add_req(REQ_UCOUNT, 8'hFF, 1'b0, '0);
        add_req(REQ_SHIFT, 8'h00, 1'b0, '0);
        add_req(REQ_FLUSH, 8'h00, 1'b0, 32'hDEAD_BEEF);
        add_req(REQ_UCOUNT, 8'h00, 1'b0, '0);
        add_req(REQ_POP, 8'h00, 1'b0, '0);
        drain();

        // High threshold of 250 and debug tag off.
        write_cfg(CFG_THRESHOLD, 8'd250);
        write_cfg(CFG_DEBUG_EN, 8'd0);
        add_random(60);
        drain();

        // Long receiver hold-off so the block fills and stalls its input.
        write_cfg(CFG_THRESHOLD, 8'd3);
        write_cfg(CFG_DEBUG_EN, 8'd1);
        hold_off = 1'b1;
        add_random(20);
        waited = 0;
        while (waited < 200) begin
            @(posedge clk);
            waited++;
        end
        hold_off = 1'b0;
        drain();

        // Idle phases with differing stall patterns.
        for (int ph = 0; ph < 4; ph++) begin
            in_idle_pct = (ph == 1 || ph == 3) ? 77 : (ph == 3 ? 8 : 0);
            out_stall_pct = (ph == 2 || ph == 3) ? 77 : 0;
            if (ph == 3) begin
                in_idle_pct = 8;
                out_stall_pct = 8;
            end
            write_cfg(CFG_THRESHOLD, (ph == 0) ? 8'd255 : 8'($urandom_range(1, 8)));
            add_random(80);
            drain();
        end

        $display("Covered %0d result beats across sample, ring and read requests,", results_seen);
        $display("several thresholds, debug tag on and off, and varied stall patterns.");
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Overall time limit.
    initial begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
